### src/assert_macros.svh
// Assertion macros shared by the swerve kinematics RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWIK_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWIK_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/swik_pkg.sv
// Package for the swerve wheel kinematics core: cell payload type,
// fixed-point constants and the CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps

package swik_pkg;

  // One root bit per cell; the chain length follows from the 64-bit radicand.
  localparam int SQRT_CELLS = 32;

  localparam logic [1:0] WHEEL_LF = 2'd0;
  localparam logic [1:0] WHEEL_RF = 2'd1;
  localparam logic [1:0] WHEEL_LB = 2'd2;
  localparam logic [1:0] WHEEL_RB = 2'd3;

  // sqrt(2)/2 in Q32, held as a positive signed value.
  localparam logic signed [32:0] SQRT_HALF_Q32  = 33'sd3037000500;
  // Angles in units of 2^-20 rad.
  localparam logic signed [23:0] PI_Q20         = 24'sd3294199;
  localparam logic signed [23:0] QUARTER_PI_Q20 = 24'sd823550;

  typedef struct packed {
    logic [1:0]         wheel;
    logic               zero;   // a = b = 0
    logic [63:0]        rem;    // radicand minus root squared
    logic [31:0]        root;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [23:0] z;
  } cell_t;

  function automatic logic signed [23:0] atan_q20(input int i);
    case (i)
      0:       return 24'sd823550;
      1:       return 24'sd486170;
      2:       return 24'sd256879;
      3:       return 24'sd130396;
      4:       return 24'sd65451;
      5:       return 24'sd32757;
      6:       return 24'sd16383;
      7:       return 24'sd8192;
      8:       return 24'sd4096;
      9:       return 24'sd2048;
      10:      return 24'sd1024;
      11:      return 24'sd512;
      12:      return 24'sd256;
      13:      return 24'sd128;
      14:      return 24'sd64;
      15:      return 24'sd32;
      16:      return 24'sd16;
      17:      return 24'sd8;
      18:      return 24'sd4;
      19:      return 24'sd2;
      20:      return 24'sd1;
      default: return 24'sd0;
    endcase
  endfunction

endpackage

### src/swik_cell.sv
// One cell of the kinematics chain: one restoring square-root bit and, when
// STAGE < CORDIC_STEPS, one CORDIC vectoring step per beat. Depends on swik_pkg.
`timescale 1ns / 1ps

module swik_cell import swik_pkg::*; #(
  parameter int STAGE        = 0,
  parameter int CORDIC_STEPS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  cell_t in_data,
  output logic  out_valid,
  output cell_t out_data
);

  localparam int                 BIT  = SQRT_CELLS - 1 - STAGE;
  localparam logic signed [23:0] ATAN = atan_q20(STAGE);

  cell_t              nxt;
  logic [64:0]        trial;
  logic signed [33:0] dx;
  logic signed [33:0] dy;

  always_comb begin
    nxt   = in_data;
    // (root + 2^BIT)^2 - root^2, root has no bits at or below BIT
    trial = (65'(in_data.root) << (BIT + 1)) | (65'd1 << (2 * BIT));
    dx    = $signed(in_data.y) >>> STAGE;
    dy    = $signed(in_data.x) >>> STAGE;
    if (65'(in_data.rem) >= trial) begin
      nxt.rem  = in_data.rem - trial[63:0];
      nxt.root = in_data.root | (32'd1 << BIT);
    end
    if (STAGE < CORDIC_STEPS) begin
      if ($signed(in_data.y) > 34'sd0) begin
        nxt.x = in_data.x + dx;
        nxt.y = in_data.y - dy;
        nxt.z = in_data.z + ATAN;
      end else begin
        nxt.x = in_data.x - dx;
        nxt.y = in_data.y + dy;
        nxt.z = in_data.z - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= nxt;
    end
  end

endmodule

### src/swik_front.sv
// Front end: command register, wheel sequencer, wheel vector forming,
// squares and CORDIC pre-rotation. Feeds the head of the cell chain.
// Depends on swik_pkg.
`timescale 1ns / 1ps

module swik_front import swik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // vel_x[15:0], vel_y[31:16], rot_rate[47:32]
  output logic        head_valid,
  output cell_t       head
);

  logic               cmd_valid;
  logic [1:0]         wheel;
  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic signed [31:0] kw;

  logic signed [48:0] kw_prod;
  logic signed [48:0] kw_round;
  logic               issue;
  logic               accept;
  logic signed [31:0] vx_q15;
  logic signed [31:0] vy_q15;
  logic signed [31:0] a_next;
  logic signed [31:0] b_next;

  // stage A: wheel vector
  logic               va_valid;
  logic [1:0]         va_wheel;
  logic signed [31:0] va_a;
  logic signed [31:0] va_b;

  // stage B: squares and pre-rotation
  logic               sq_valid;
  logic [1:0]         sq_wheel;
  logic signed [63:0] sq_a;
  logic signed [63:0] sq_b;
  logic signed [33:0] pr_x;
  logic signed [33:0] pr_y;
  logic signed [23:0] pr_z;
  logic               pr_zero;
  logic signed [33:0] a_ext;
  logic signed [33:0] b_ext;

  // k * rot_rate, rounded half up to Q15
  assign kw_prod  = $signed(s_tdata[47:32]) * SQRT_HALF_Q32;
  assign kw_round = (kw_prod + 49'sd65536) >>> 17;

  assign issue    = adv && cmd_valid;
  assign accept   = s_tvalid && s_tready;
  assign s_tready = !cmd_valid || (issue && (wheel == WHEEL_RB));

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      wheel     <= WHEEL_LF;
    end else begin
      if (issue) begin
        wheel <= wheel + 2'd1;
      end
      if (accept) begin
        cmd_valid <= 1'b1;
      end else if (issue && (wheel == WHEEL_RB)) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vx <= $signed(s_tdata[15:0]);
      vy <= $signed(s_tdata[31:16]);
      kw <= kw_round[31:0];
    end
  end

  assign vx_q15 = {vx[15], vx, 15'd0};
  assign vy_q15 = {vy[15], vy, 15'd0};

  always_comb begin
    if ((wheel == WHEEL_RF) || (wheel == WHEEL_LB)) begin
      a_next = vx_q15 + kw;
    end else begin
      a_next = vx_q15 - kw;
    end
    if ((wheel == WHEEL_LB) || (wheel == WHEEL_RB)) begin
      b_next = vy_q15 + kw;
    end else begin
      b_next = vy_q15 - kw;
    end
  end

  assign a_ext = {{2{va_a[31]}}, va_a};
  assign b_ext = {{2{va_b[31]}}, va_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      va_valid   <= 1'b0;
      sq_valid   <= 1'b0;
      head_valid <= 1'b0;
    end else if (adv) begin
      va_valid   <= cmd_valid;
      sq_valid   <= va_valid;
      head_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      va_wheel <= wheel;
      va_a     <= a_next;
      va_b     <= b_next;

      sq_wheel <= va_wheel;
      sq_a     <= va_a * va_a;
      sq_b     <= va_b * va_b;
      pr_zero  <= (va_a == 32'sd0) && (va_b == 32'sd0);
      // left half plane: rotate by pi so CORDIC starts with x >= 0
      if (va_a < 32'sd0) begin
        pr_x <= -a_ext;
        pr_y <= -b_ext;
        pr_z <= (va_b >= 32'sd0) ? PI_Q20 : -PI_Q20;
      end else begin
        pr_x <= a_ext;
        pr_y <= b_ext;
        pr_z <= 24'sd0;
      end

      head.wheel <= sq_wheel;
      head.zero  <= pr_zero;
      head.rem   <= sq_a + sq_b;
      head.root  <= 32'd0;
      head.x     <= pr_x;
      head.y     <= pr_y;
      head.z     <= pr_z;
    end
  end

endmodule

### src/swerve_wheel_inverse_kinematics_core.sv
// Top level of the four-wheel swerve drive inverse kinematics core.
// Depends on swik_pkg, swik_front, swik_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One chassis command beat (vel_x, vel_y, rot_rate) gives four wheel beats,
// left front, right front, left back, right back, the last one with tlast.
// Each wheel beat carries the rounded speed magnitude and the steering angle
// atan2(b, a) - pi/4 in 1/4096 rad, no wrap; a zero vector gives -3217.
// Rate: one wheel beat per cycle unless m_tready stalls; the wheel
// sequencer issues one wheel per advancing cycle into a single shared
// chain of 32 cells, each doing one square-root bit and, for the first
// CORDIC_STEPS cells, one CORDIC step. A new command is taken in the cycle
// its predecessor's last wheel is issued, so commands overlap in the chain.
// Back-pressure on m_tready freezes the whole chain.

module swerve_wheel_inverse_kinematics_core import swik_pkg::*; #(
  parameter int CORDIC_STEPS = 16  // CORDIC iterations, 8 to 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // vel_x[15:0], vel_y[31:16], rot_rate[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // wheel_speed[16:0], wheel_angle[31:17]
  output logic [1:0]  m_tuser,   // wheel_index[1:0]
  output logic        m_tlast
);

  // chain advances whenever the output register is free or being drained
  logic  adv;
  logic  chain_valid [0:SQRT_CELLS];
  cell_t chain       [0:SQRT_CELLS];

  cell_t              tail;
  logic [32:0]        spd_sum;
  logic signed [23:0] z_eff;
  logic signed [23:0] ang_sum;

  assign adv = !m_tvalid || m_tready;

  swik_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .head_valid (chain_valid[0]),
    .head       (chain[0])
  );

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_cell
    swik_cell #(
      .STAGE        (i),
      .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (chain_valid[i]),
      .in_data   (chain[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain[i+1])
    );
  end

  // final rounding of root and angle
  assign tail    = chain[SQRT_CELLS];
  assign spd_sum = {1'b0, tail.root} + 33'd16384;
  assign z_eff   = tail.zero ? 24'sd0 : tail.z;
  assign ang_sum = z_eff - QUARTER_PI_Q20 + 24'sd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= chain_valid[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {ang_sum[22:8], spd_sum[31:15]};
      m_tuser <= tail.wheel;
      m_tlast <= (tail.wheel == WHEEL_RB);
    end
  end

  // an accepted command beat is not immediately followed by another
  `SWIK_ASSERT_NXT(a_cmd_busy, clk, rst, s_tvalid && s_tready, !s_tready, "ready after accept")
  // stalled chain head keeps its beat
  `SWIK_ASSERT_NXT(a_head_hold, clk, rst, !adv && chain_valid[0], chain_valid[0] && $stable(chain[0]), "head moved during stall")
  // zero flag and radicand stay aligned through the front stages
  `SWIK_ASSERT_IMP(a_zero_rem, clk, rst, chain_valid[0] && chain[0].zero, chain[0].rem == 64'd0, "zero vector with nonzero radicand")

endmodule
